// ===== rtl/core/bvst_pkg.sv =====
// Package for the bounded value set table: capacity, derived widths, status codes
// and a helper for the count output.
// Depends on nothing; used by bounded_value_set_table_unit.
package bvst_pkg;

	localparam int CAPACITY = 128;

	localparam int VALUE_W = 32;
	localparam int SET_COUNT_W = 8;
	localparam int STATUS_W = 3;

	// The memory index needs enough bits for the depth.
	// The count needs one more value, so that it can hold CAPACITY itself.
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL = 3'd2,
		ST_REMOVED = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	// Gives the low bits of the count at the width of the set_count field,
	// padding with zeros when the count is narrower.
	function automatic logic [SET_COUNT_W-1:0] to_set_count(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+SET_COUNT_W-1:0] ext;
		ext = {{SET_COUNT_W{1'b0}}, cnt};
		return ext[SET_COUNT_W-1:0];
	endfunction

endpackage

// ===== rtl/core/bounded_value_set_table_unit.sv =====
// Top level of the bounded value set table: sequencer, entry memory and output register.
// Depends on bvst_pkg for the capacity, widths and status codes.
// Takes one request word at a time and returns one result word per request.

// The unit holds a set of distinct 32-bit values in a memory of bvst_pkg::CAPACITY
// entries, kept in insertion order, with a count of held entries. Each request word
// (insert or remove) yields exactly one result word carrying the new count and a status.
// Requests are handled one at a time: in_stall is high from acceptance until the result
// has been placed in the output register, which may still be waiting to be taken while the
// next request is accepted. Timing is set by the single memory read port, which the
// search walks one entry per cycle, and by its registered data, so that each entry is
// compared in the cycle after it is read. An insert into a full table goes straight to
// the result; a request that finds no match first compares every held entry; a request
// that matches stops its search at the hit, and a remove that matches before the last
// entry then moves the later entries down one place, one per cycle. The result then
// waits in S_FINISH while the previous result is still held up in the output register.
// Values are compared as raw bit patterns. Entries at or above the count are never read,
// so the memory needs no clearing after reset and the unit is ready straight away.
module bounded_value_set_table_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic signed [bvst_pkg::VALUE_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bvst_pkg::SET_COUNT_W-1:0]    set_count,
	output logic [bvst_pkg::STATUS_W-1:0]       status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_FINISH
	} state_t;

	state_t state_q;

	// Request being worked on.
	logic                          remove_q;
	logic [bvst_pkg::VALUE_W-1:0]  value_q;

	// Number of held entries.
	logic [bvst_pkg::CNT_W-1:0]    count_q;

	// idx_q is the next address to read. cmp_idx_q is the address whose data now
	// sits in rd_data_q, and cmp_vld_q says that this data is there at all.
	logic [bvst_pkg::CNT_W-1:0]    idx_q;
	logic [bvst_pkg::CNT_W-1:0]    cmp_idx_q;
	logic                          cmp_vld_q;

	bvst_pkg::status_t             status_pend_q;

	// Output register.
	logic                          out_valid_q;
	logic [bvst_pkg::SET_COUNT_W-1:0] set_count_q;
	bvst_pkg::status_t             status_q;

	// Entry memory: one write port and one registered read port.
	logic [bvst_pkg::VALUE_W-1:0]  mem [bvst_pkg::CAPACITY];
	logic [bvst_pkg::VALUE_W-1:0]  rd_data_q;

	logic                          rd_en;
	logic [bvst_pkg::IDX_W-1:0]    rd_addr;
	logic                          wr_en;
	logic [bvst_pkg::IDX_W-1:0]    wr_addr;
	logic [bvst_pkg::VALUE_W-1:0]  wr_data;

	logic                          in_accept;
	logic                          idx_in_range;
	logic                          hit;
	logic [bvst_pkg::CNT_W-1:0]    shift_dest;
	logic                          out_free;

	assign in_accept = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	assign idx_in_range = (idx_q < count_q);
	assign hit = cmp_vld_q && (rd_data_q == value_q);
	assign shift_dest = cmp_idx_q - bvst_pkg::CNT_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// Memory port control. During the search the read port walks the held entries;
	// a read is skipped once a hit has been seen. During the shift each entry read in
	// one cycle is written one place lower in the next.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[bvst_pkg::IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = count_q[bvst_pkg::IDX_W-1:0];
		wr_data = value_q;
		case (state_q)
			S_SEARCH: begin
				rd_en = !hit && idx_in_range;
				// A miss on insert appends the value behind the last held entry.
				wr_en = !hit && !idx_in_range && !remove_q;
			end
			S_SHIFT: begin
				rd_en = idx_in_range;
				wr_en = cmp_vld_q;
				wr_addr = shift_dest[bvst_pkg::IDX_W-1:0];
				wr_data = rd_data_q;
			end
			default: begin
				rd_en = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			remove_q <= 1'b0;
			value_q <= '0;
			count_q <= '0;
			idx_q <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			status_pend_q <= bvst_pkg::ST_INSERTED;
			out_valid_q <= 1'b0;
			set_count_q <= '0;
			status_q <= bvst_pkg::ST_INSERTED;
		end else begin
			// In S_FINISH the output register is reloaded below whenever it is free.
			if (out_valid_q && !out_stall && (state_q != S_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						remove_q <= req_type;
						value_q <= $unsigned(value);
						idx_q <= '0;
						cmp_vld_q <= 1'b0;
						// A full table drops an insert before any search.
						if (!req_type && (count_q >= bvst_pkg::CAP_CNT)) begin
							status_pend_q <= bvst_pkg::ST_FULL;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end

				S_SEARCH: begin
					if (hit) begin
						if (!remove_q) begin
							status_pend_q <= bvst_pkg::ST_DUPLICATE;
							state_q <= S_FINISH;
						end else if ((cmp_idx_q + bvst_pkg::CNT_W'(1)) < count_q) begin
							// Later entries exist and must move down one place.
							idx_q <= cmp_idx_q + bvst_pkg::CNT_W'(1);
							cmp_vld_q <= 1'b0;
							state_q <= S_SHIFT;
						end else begin
							// The last entry was hit, so dropping the count removes it.
							count_q <= count_q - bvst_pkg::CNT_W'(1);
							status_pend_q <= bvst_pkg::ST_REMOVED;
							state_q <= S_FINISH;
						end
					end else if (idx_in_range) begin
						cmp_idx_q <= idx_q;
						cmp_vld_q <= 1'b1;
						idx_q <= idx_q + bvst_pkg::CNT_W'(1);
					end else begin
						// Every held entry has been compared without a match.
						if (remove_q) begin
							status_pend_q <= bvst_pkg::ST_NOT_FOUND;
						end else begin
							count_q <= count_q + bvst_pkg::CNT_W'(1);
							status_pend_q <= bvst_pkg::ST_INSERTED;
						end
						state_q <= S_FINISH;
					end
				end

				S_SHIFT: begin
					if (idx_in_range) begin
						cmp_idx_q <= idx_q;
						cmp_vld_q <= 1'b1;
						idx_q <= idx_q + bvst_pkg::CNT_W'(1);
					end else begin
						// The last pending word is written this cycle.
						cmp_vld_q <= 1'b0;
						count_q <= count_q - bvst_pkg::CNT_W'(1);
						status_pend_q <= bvst_pkg::ST_REMOVED;
						state_q <= S_FINISH;
					end
				end

				S_FINISH: begin
					// Wait here only while the previous result is still held up.
					if (out_free) begin
						out_valid_q <= 1'b1;
						set_count_q <= bvst_pkg::to_set_count(count_q);
						status_q <= status_pend_q;
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign set_count = set_count_q;
	assign status = status_q;

endmodule
